/* src/assert_macros.svh */
// Assertion macros used by the deque RTL.
// No dependencies; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check that holds in the cycle of the trigger.
`define ASSERT_IMPL(label, trig, cons, msg) \
  `ASSERT_CLK(label, (trig) |-> (cons), msg)

`endif

/* src/bdq_pkg.sv */
// Types and constants for the bounded record deque.
// No dependencies; used by the controller, the datapath and the top level.
package bdq_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_BACK   = 2'd2
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;  // latch the request fields
    logic exec;     // run the latched request against the ring
  } cmd_t;

endpackage

/* src/bdq_ctrl.sv */
// Request sequencer for the deque: idle, execute, respond.
// Depends on bdq_pkg.
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output bdq_pkg::cmd_t cmd_o
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o   = (state_q == S_RESP);
  assign cmd_o.capture = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.exec    = (state_q == S_EXEC);

endmodule

/* src/bdq_datapath.sv */
// Ring store, front pointer, count and result registers of the deque.
// Depends on bdq_pkg; commanded by bdq_ctrl.
module bdq_datapath #(
  parameter int unsigned DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdq_pkg::cmd_t                       cmd_i,
  input  logic [bdq_pkg::ACT_W-1:0]           action_i,
  input  logic signed [bdq_pkg::KEY_W-1:0]    entry_key_i,
  input  logic [bdq_pkg::SCORE_W-1:0]         entry_score_i,
  output logic signed [bdq_pkg::KEY_W-1:0]    popped_key_o,
  output logic [bdq_pkg::SCORE_W-1:0]         popped_score_o,
  output logic [bdq_pkg::STAT_W-1:0]          status_o,
  output logic                                empty_flag_o,
  output logic [bdq_pkg::COUNT_W-1:0]         entry_count_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // Ring storage
  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [SCORE_W-1:0] score_mem [DEPTH];

  // Latched request
  logic [ACT_W-1:0]   act_q;
  logic [KEY_W-1:0]   key_q;
  logic [SCORE_W-1:0] score_q;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  stat_e         status_q, status_d;
  logic          pop_ok_q, pop_ok_d;
  logic [KEY_W-1:0]   rd_key_q;
  logic [SCORE_W-1:0] rd_score_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] idx;
  logic [SW-1:0] back_sum, last_sum;
  logic [AW-1:0] back_idx, last_idx, front_dec;
  logic          full, empty;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // Slot after the back record and slot of the back record, wrapped once.
  assign back_sum = SW'(front_q) + SW'(count_q);
  assign last_sum = back_sum - SW'(1);
  assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign last_idx = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    idx      = back_idx;
    if (cmd_i.exec) begin
      status_d = ST_DONE;
      pop_ok_d = 1'b0;
      unique case (act_q)
        ACT_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            front_d = front_dec;
            idx     = front_dec;
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            idx     = back_idx;
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            idx      = last_idx;
            rd_en    = 1'b1;
            pop_ok_d = 1'b1;
            count_d  = count_q - CW'(1);
          end
        end
        default: begin
          // unused code: no operation
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      key_q   <= entry_key_i;
      score_q <= entry_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= ST_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[idx]   <= key_q;
      score_mem[idx] <= score_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q   <= key_mem[idx];
      rd_score_q <= score_mem[idx];
    end
  end

  logic [CW+COUNT_W-1:0] count_ext;
  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  assign popped_key_o   = pop_ok_q ? $signed(rd_key_q) : '0;
  assign popped_score_o = pop_ok_q ? rd_score_q : '0;
  assign status_o       = status_q;
  assign empty_flag_o   = empty;
  assign entry_count_o  = count_ext[COUNT_W-1:0];

endmodule

/* src/bounded_record_deque_core.sv */
// Top level of the bounded record deque: sequencer plus ring datapath.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath and assert_macros.svh.
//
//   channel  | dir | tdata (low bit up)                        | tuser
//   s_axis   | in  | entry_key[31:0], entry_score[47:32]       | action[1:0]
//   m_axis   | out | popped_key[31:0], popped_score[47:32],    | status[1:0]
//            |     | empty_flag[48], entry_count[53:49]        |
//
// One request at a time: accept, execute at the single-port ring memory,
// then the result is presented; the next request is not taken until
// m_axis_tready takes the result. The registered memory read is done in the execute state.
// rst_ni clears the pointer, count, status, pop flag and sequencer; the ring needs no clearing.
// A stalled result holds s_axis_tready low until it is taken.
`include "assert_macros.svh"

module bounded_record_deque_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // entry_key, entry_score
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // popped_key, popped_score, empty_flag, entry_count, pad
  output logic [1:0]  m_axis_tuser    // status
);
  import bdq_pkg::*;

  cmd_t                cmd;
  logic signed [KEY_W-1:0] popped_key;
  logic [SCORE_W-1:0]  popped_score;
  logic [STAT_W-1:0]   status;
  logic                empty_flag;
  logic [COUNT_W-1:0]  entry_count;
  logic                rsp_error;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (s_axis_tuser),
    .entry_key_i    ($signed(s_axis_tdata[31:0])),
    .entry_score_i  (s_axis_tdata[47:32]),
    .popped_key_o   (popped_key),
    .popped_score_o (popped_score),
    .status_o       (status),
    .empty_flag_o   (empty_flag),
    .entry_count_o  (entry_count)
  );

  assign m_axis_tdata = {2'b00, entry_count, empty_flag, popped_score, popped_key};
  assign m_axis_tuser = status;

  assign rsp_error = m_axis_tvalid && (m_axis_tuser != ST_DONE);

  // Only one request in flight: never ready for input while a result is shown.
  `ASSERT_CLK(a_one_in_flight, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  // A result is shown in the respond state, which follows the execute state after a request is taken.
  `ASSERT_CLK(a_rsp_latency, (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid, "no result")
  // A failed request carries a zero record.
  `ASSERT_IMPL(a_err_zero, rsp_error, m_axis_tdata[47:0] == '0, "record not zero")

endmodule
